@@ hw/rtl/w8w16_pkg.sv @@
// Types and constants shared by the WTF-8 to UTF-16LE transcoder.
package w8w16_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       string_done;
    logic       string_valid;
  } out_item_t;

  typedef struct packed {
    logic [15:0] hi_unit;
    logic [15:0] lo_unit;
    logic        pair;
    logic        done;
    logic        valid;
  } unit_job_t;

  localparam logic [20:0] CP_LIMIT    = 21'h110000;
  localparam logic [20:0] CP_BMP_END  = 21'h010000;
  localparam logic [20:0] CP_REPLACE  = 21'h00FFFD;
  localparam logic [20:0] CP_HIGH_LO  = 21'h00D800;
  localparam logic [20:0] CP_LOW_LO   = 21'h00DC00;
  localparam logic [20:0] CP_LOW_END  = 21'h00E000;
  localparam logic [15:0] UNIT_HIGH   = 16'hD800;
  localparam logic [15:0] UNIT_LOW    = 16'hDC00;
  localparam logic [1:0]  CONT_TAG    = 2'b10;

endpackage

@@ hw/rtl/w8w16_front.sv @@
// Front end: decodes WTF-8 bytes into UTF-16 unit requests.
module w8w16_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  w8w16_pkg::in_item_t   item,
  output logic                  push,
  output w8w16_pkg::unit_job_t  job
);

  logic [1:0]  bytes_pending, bytes_pending_next;
  logic [20:0] code_accumulator, code_accumulator_next;
  logic        sequence_bad, sequence_bad_next;
  logic        prev_high_surrogate, prev_high_surrogate_next;
  logic        valid_so_far, valid_so_far_next;

  logic        emit;
  logic        emit_bad;
  logic [20:0] emit_cp;
  logic [20:0] acc_shift;
  logic [1:0]  pending_dec;
  logic        cont_bad;
  logic        replace;
  logic [20:0] cp;
  logic        is_high;
  logic        is_low;
  logic [20:0] offset;
  logic        eos;
  logic [7:0]  b;

  always_comb begin
    b = item.in_byte;
    eos = item.end_of_string;
    bytes_pending_next = bytes_pending;
    code_accumulator_next = code_accumulator;
    sequence_bad_next = sequence_bad;
    emit = 1'b0;
    emit_bad = 1'b0;
    emit_cp = 21'd0;
    cont_bad = (b[7:6] != w8w16_pkg::CONT_TAG);
    acc_shift = {code_accumulator[14:0], b[5:0]};
    pending_dec = bytes_pending - 2'd1;

    if (bytes_pending == 2'd0) begin
      if (b[7] == 1'b0) begin
        emit = 1'b1;
        emit_cp = {13'd0, b};
      end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
        sequence_bad_next = 1'b0;
        if (b[7:5] == 3'b110) begin
          code_accumulator_next = {16'd0, b[4:0]};
          bytes_pending_next = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          code_accumulator_next = {17'd0, b[3:0]};
          bytes_pending_next = 2'd2;
        end else begin
          code_accumulator_next = {18'd0, b[2:0]};
          bytes_pending_next = 2'd3;
        end
        if (eos) begin
          emit = 1'b1;
          emit_bad = 1'b1;
        end
      end else begin
        emit = 1'b1;
        emit_bad = 1'b1;
      end
    end else begin
      code_accumulator_next = acc_shift;
      bytes_pending_next = pending_dec;
      if (pending_dec == 2'd0) begin
        emit = 1'b1;
        emit_cp = acc_shift;
        emit_bad = sequence_bad | cont_bad;
        sequence_bad_next = 1'b0;
        code_accumulator_next = 21'd0;
      end else begin
        sequence_bad_next = sequence_bad | cont_bad;
        if (eos) begin
          emit = 1'b1;
          emit_bad = 1'b1;
        end
      end
    end

    replace = emit_bad || (emit_cp >= w8w16_pkg::CP_LIMIT);
    cp = replace ? w8w16_pkg::CP_REPLACE : emit_cp;
    is_high = (cp >= w8w16_pkg::CP_HIGH_LO) && (cp < w8w16_pkg::CP_LOW_LO);
    is_low = (cp >= w8w16_pkg::CP_LOW_LO) && (cp < w8w16_pkg::CP_LOW_END);
    offset = cp - w8w16_pkg::CP_BMP_END;

    valid_so_far_next = valid_so_far;
    prev_high_surrogate_next = prev_high_surrogate;
    if (emit) begin
      valid_so_far_next = valid_so_far && !replace && !(prev_high_surrogate && is_low);
      prev_high_surrogate_next = is_high;
    end

    job.valid = valid_so_far_next;
    job.done = eos;
    if (cp < w8w16_pkg::CP_BMP_END) begin
      job.pair = 1'b0;
      job.hi_unit = cp[15:0];
      job.lo_unit = cp[15:0];
    end else begin
      job.pair = 1'b1;
      job.hi_unit = w8w16_pkg::UNIT_HIGH + {6'd0, offset[19:10]};
      job.lo_unit = w8w16_pkg::UNIT_LOW + {6'd0, offset[9:0]};
    end

    push = accept && emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      code_accumulator <= 21'd0;
      sequence_bad <= 1'b0;
      prev_high_surrogate <= 1'b0;
      valid_so_far <= 1'b1;
    end else if (accept) begin
      if (eos) begin
        bytes_pending <= 2'd0;
        code_accumulator <= 21'd0;
        sequence_bad <= 1'b0;
        prev_high_surrogate <= 1'b0;
        valid_so_far <= 1'b1;
      end else begin
        bytes_pending <= bytes_pending_next;
        code_accumulator <= code_accumulator_next;
        sequence_bad <= sequence_bad_next;
        prev_high_surrogate <= prev_high_surrogate_next;
        valid_so_far <= valid_so_far_next;
      end
    end
  end

endmodule

@@ hw/rtl/w8w16_queue.sv @@
// Small first-in first-out queue of unit requests between front and back.
module w8w16_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  w8w16_pkg::unit_job_t  push_job,
  input  logic                  pop,
  output w8w16_pkg::unit_job_t  pop_job,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  w8w16_pkg::unit_job_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/w8w16_back.sv @@
// Back end: serialises each unit request into little-endian output bytes.
module w8w16_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  w8w16_pkg::unit_job_t  q_job,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output w8w16_pkg::out_item_t  out_data
);

  w8w16_pkg::unit_job_t cur;
  logic        cur_valid;
  logic [1:0]  idx;
  logic        out_load;
  logic        last_byte;
  logic        take;
  logic [15:0] unit;
  logic [7:0]  byte_sel;

  assign last_byte = (idx == (cur.pair ? 2'd3 : 2'd1));
  assign out_load = cur_valid && (!out_valid || out_ready);
  assign take = !cur_valid || (out_load && last_byte);
  assign q_pop = take && !q_empty;
  assign unit = idx[1] ? cur.lo_unit : cur.hi_unit;
  assign byte_sel = idx[0] ? unit[15:8] : unit[7:0];

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
    if (out_load) begin
      out_data.out_byte <= byte_sel;
      out_data.last_of_run <= last_byte;
      out_data.string_done <= last_byte && cur.done;
      out_data.string_valid <= cur.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        cur_valid <= !q_empty;
        idx <= 2'd0;
      end else if (out_load) begin
        idx <= idx + 2'd1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/wtf8_to_wtf16_transcoder.sv @@
// Top level of the WTF-8 to UTF-16LE transcoder.
// Input requests carry one WTF-8 byte and an end-of-string mark on in_data,
// accepted when in_valid and in_ready are both high. Output requests carry
// one UTF-16LE byte each on out_data, with last_of_run on the final byte
// caused by an input byte, string_done on the final byte of the string and
// the running validity flag in string_valid.
// The front end decodes one input byte per cycle while in_ready is high
// and, when a code point is complete, writes a unit request into a queue of
// QUEUE_DEPTH entries. The back end drains that queue at one output byte per
// cycle while out_ready allows, so a code point yields two output bytes, or
// four for a surrogate pair; the output byte channel sets the sustained rate.
// A request is registered in the queue, then the back end, then out_data.
// in_ready is low only while the queue is full. When the receiver stalls
// the output register holds its request, the back end waits, the queue fills
// and the input side then stops; no request is lost.
// Reset clears the decoder state, the queue and the output register; the
// validity flag starts high and returns high after each end of string.
module wtf8_to_wtf16_transcoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  w8w16_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output w8w16_pkg::out_item_t  out_data
);

  logic                  accept;
  logic                  push;
  w8w16_pkg::unit_job_t  push_job;
  logic                  q_pop;
  w8w16_pkg::unit_job_t  q_job;
  logic                  q_full;
  logic                  q_empty;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;

  w8w16_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_data),
    .push   (push),
    .job    (push_job)
  );

  w8w16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (q_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  w8w16_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("request written into a full queue");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("queue reports full and empty together");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.string_done |-> out_data.last_of_run)
    else $error("end of string not on the last byte of a run");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("request read from an empty queue");

endmodule
